### design/abc_pkg.sv
// Package: shared types, constants and the lux-to-level boundary table.
`default_nettype none

package abc_pkg;

    localparam int LUX_W   = 16;
    localparam int LEVEL_W = 8;
    localparam int DELTA_W = 9;
    localparam int IDX_W   = 3;
    localparam int ROM_SIZE = 255;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_AUTO   = 2'd1,
        CMD_LEVEL  = 2'd2,
        CMD_ADJUST = 2'd3
    } t_cmd;

    typedef enum logic [IDX_W-1:0] {
        REG_MIN_LEVEL  = 3'd0,
        REG_MAX_LEVEL  = 3'd1,
        REG_AVG_SHIFT  = 3'd2,
        REG_RAMP_UP    = 3'd3,
        REG_RAMP_DOWN  = 3'd4,
        REG_HOLD_UP    = 3'd5,
        REG_HOLD_DOWN  = 3'd6
    } t_reg_idx;

    localparam logic [7:0] RST_MIN_LEVEL = 8'd1;
    localparam logic [7:0] RST_MAX_LEVEL = 8'd100;
    localparam logic [3:0] RST_AVG_SHIFT = 4'd4;
    localparam logic [7:0] RST_RAMP_UP   = 8'd2;
    localparam logic [7:0] RST_RAMP_DOWN = 8'd1;
    localparam logic [7:0] RST_HOLD_UP   = 8'd5;
    localparam logic [7:0] RST_HOLD_DOWN = 8'd6;

    typedef struct packed {
        logic [7:0] min_level;
        logic [7:0] max_level;
        logic [3:0] average_shift;
        logic [7:0] ramp_up_step;
        logic [7:0] ramp_down_step;
        logic [7:0] hold_up_margin;
        logic [7:0] hold_down_margin;
    } t_cfg;

    typedef struct packed {
        t_cmd                       cmd;
        logic                       enable;
        logic [LEVEL_W-1:0]         manual_level;
        logic signed [DELTA_W-1:0]  adjust_delta;
        logic                       auto_old;
        logic                       auto_new;
        logic                       sample_on;
        logic                       reload;
    } t_item;

    typedef logic [ROM_SIZE-1:0][31:0] t_rom;

    localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;

    function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] exp_q62(logic half, logic neg);
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] dv;
        logic        done;
        sum  = Q62_ONE;
        term = Q62_ONE;
        done = 1'b0;
        dv   = half ? 64'd30 : 64'd15;
        for (int n = 1; n < 64; n++) begin
            if (!done) begin
                term = div_u64(term, dv * 64'(n));
                if (term == 64'd0) begin
                    done = 1'b1;
                end else if (neg && n[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return sum;
    endfunction

    function automatic logic [31:0] ceil_q38(logic [63:0] v);
        logic [63:0] c;
        c = (v >> 38) + {63'd0, |v[37:0]};
        return c[31:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] up;
        logic [63:0] down;
        logic [63:0] base;
        logic [63:0] v;
        logic        capped;
        up     = exp_q62(1'b0, 1'b0);
        down   = exp_q62(1'b0, 1'b1);
        base   = (exp_q62(1'b1, 1'b0) >> 24) * 64'd50;
        rom    = '0;
        rom[50] = ceil_q38(base);
        v = base;
        for (int k = 50; k >= 1; k--) begin
            v = mul_q62(v, down);
            rom[k-1] = ceil_q38(v);
        end
        v = base;
        capped = 1'b0;
        for (int k = 52; k <= ROM_SIZE; k++) begin
            if (!capped) begin
                v = mul_q62(v, up);
                if (v >= Q62_ONE) begin
                    capped = 1'b1;
                end
            end
            rom[k-1] = capped ? 32'hFFFF_FFFF : ceil_q38(v);
        end
        return rom;
    endfunction

    localparam t_rom LEVEL_ROM = build_rom();

    function automatic logic [7:0] clamp_level(logic signed [10:0] v,
                                              logic [7:0] lo, logic [7:0] hi);
        if (v < $signed({3'b000, lo})) begin
            return lo;
        end else if (v > $signed({3'b000, hi})) begin
            return hi;
        end
        return v[7:0];
    endfunction

endpackage

`default_nettype wire

### design/abc_in_if.sv
// Interface: command item channel.
`default_nettype none

interface abc_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [15:0]       lux;
    logic              enable;
    logic [7:0]        manual_level;
    logic signed [8:0] adjust_delta;

    modport source (output valid, command, lux, enable, manual_level, adjust_delta,
                    input ready);
    modport sink   (input valid, command, lux, enable, manual_level, adjust_delta,
                    output ready);
endinterface

`default_nettype wire

### design/abc_out_if.sv
// Interface: result item channel.
`default_nettype none

interface abc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] level;
    logic       auto_on;
    logic       drive_write;
    logic       notify;

    modport source (output valid, level, auto_on, drive_write, notify, input ready);
    modport sink   (input valid, level, auto_on, drive_write, notify, output ready);
endinterface

`default_nettype wire

### design/abc_cfg_if.sv
// Interface: configuration write channel.
`default_nettype none

interface abc_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/abc_cfg_regs.sv
// Configuration register file.
`default_nettype none

module abc_cfg_regs import abc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    abc_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_MIN_LEVEL: n_cfg.min_level        = i_cfg.data;
                REG_MAX_LEVEL: n_cfg.max_level        = i_cfg.data;
                REG_AVG_SHIFT: n_cfg.average_shift    = i_cfg.data[3:0];
                REG_RAMP_UP:   n_cfg.ramp_up_step     = i_cfg.data;
                REG_RAMP_DOWN: n_cfg.ramp_down_step   = i_cfg.data;
                REG_HOLD_UP:   n_cfg.hold_up_margin   = i_cfg.data;
                REG_HOLD_DOWN: n_cfg.hold_down_margin = i_cfg.data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_level        <= RST_MIN_LEVEL;
            r_cfg.max_level        <= RST_MAX_LEVEL;
            r_cfg.average_shift    <= RST_AVG_SHIFT;
            r_cfg.ramp_up_step     <= RST_RAMP_UP;
            r_cfg.ramp_down_step   <= RST_RAMP_DOWN;
            r_cfg.hold_up_margin   <= RST_HOLD_UP;
            r_cfg.hold_down_margin <= RST_HOLD_DOWN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

### design/abc_avg.sv
// Input stage: mode state and exponential lux average.
`default_nettype none

module abc_avg import abc_pkg::*; #(
    parameter int LUX_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    abc_in_if.sink                 i_in,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output t_item                  o_item,
    output logic [LUX_BITS-1:0]    o_avg
);

    localparam int EXT_W = (LUX_BITS > LUX_W) ? LUX_BITS : LUX_W;
    localparam int AW    = EXT_W + 1;
    localparam logic [EXT_W-1:0] LUX_MAX = EXT_W'((64'd1 << LUX_BITS) - 64'd1);

    logic                r_valid;
    t_item               r_item;
    logic [LUX_BITS-1:0] r_avg;
    logic                r_auto;
    logic                r_reload;

    t_item               n_item;
    logic [LUX_BITS-1:0] n_avg;
    logic                n_auto;
    logic                n_reload;

    logic                take;
    logic [EXT_W-1:0]    lux_ext;
    logic [EXT_W-1:0]    lux_sat;
    logic [EXT_W-1:0]    avg_ext;
    logic [AW-1:0]       mask;
    logic [AW-1:0]       rise;
    logic [AW-1:0]       fall;

    assign i_in.ready = !r_valid || i_ready;
    assign take       = i_in.valid && i_in.ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;
    assign o_avg      = r_avg;

    always_comb begin
        lux_ext = EXT_W'(i_in.lux);
        lux_sat = (lux_ext > LUX_MAX) ? LUX_MAX : lux_ext;
        avg_ext = EXT_W'(r_avg);
        mask    = (AW'(1) << i_cfg.average_shift) - AW'(1);
        rise    = AW'(lux_sat - avg_ext) >> i_cfg.average_shift;
        fall    = (AW'(avg_ext - lux_sat) + mask) >> i_cfg.average_shift;

        n_avg    = r_avg;
        n_auto   = r_auto;
        n_reload = r_reload;

        n_item.cmd          = t_cmd'(i_in.command);
        n_item.enable       = i_in.enable;
        n_item.manual_level = i_in.manual_level;
        n_item.adjust_delta = i_in.adjust_delta;
        n_item.auto_old     = r_auto;
        n_item.sample_on    = 1'b0;
        n_item.reload       = 1'b0;

        case (t_cmd'(i_in.command))
            CMD_SAMPLE: begin
                if (r_auto) begin
                    n_item.sample_on = 1'b1;
                    n_item.reload    = r_reload;
                    n_reload         = 1'b0;
                    if (r_reload) begin
                        n_avg = LUX_BITS'(lux_sat);
                    end else if (lux_sat >= avg_ext) begin
                        n_avg = r_avg + LUX_BITS'(rise);
                    end else begin
                        n_avg = r_avg - LUX_BITS'(fall);
                    end
                end
            end
            CMD_AUTO: begin
                n_auto   = i_in.enable;
                n_reload = 1'b1;
            end
            default: begin
                n_auto   = 1'b0;
                n_reload = 1'b1;
            end
        endcase
        n_item.auto_new = n_auto;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_avg    <= '0;
            r_auto   <= 1'b0;
            r_reload <= 1'b1;
        end else if (take) begin
            r_valid  <= 1'b1;
            r_avg    <= n_avg;
            r_auto   <= n_auto;
            r_reload <= n_reload;
        end else if (i_ready) begin
            r_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

### design/abc_map.sv
// Map stage: boundary compare, thermometer decode and range clamp.
`default_nettype none

module abc_map import abc_pkg::*; #(
    parameter int LUX_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire t_item             i_item,
    input  wire logic [LUX_BITS-1:0] i_avg,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output t_item                  o_item,
    output logic [LEVEL_W-1:0]     o_mapped
);

    logic               r_valid;
    t_item              r_item;
    logic [LEVEL_W-1:0] r_mapped;

    logic [ROM_SIZE-1:0] therm;
    logic [LEVEL_W-1:0]  count;
    logic                take;

    assign o_ready  = !r_valid || i_ready;
    assign take     = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_item   = r_item;
    assign o_mapped = r_mapped;

    always_comb begin
        for (int k = 0; k < ROM_SIZE; k++) begin
            therm[k] = 32'(i_avg) >= LEVEL_ROM[k];
        end
    end

    // ones in the thermometer sit at the low end: binary search for its length
    always_comb begin
        logic [LEVEL_W-1:0] idx;
        logic [LEVEL_W-1:0] probe;
        idx = '0;
        for (int b = LEVEL_W - 1; b >= 0; b--) begin
            probe = idx + (LEVEL_W'(1) << b) - LEVEL_W'(1);
            if (therm[probe]) begin
                idx = idx + (LEVEL_W'(1) << b);
            end
        end
        count = idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item   <= i_item;
            r_mapped <= clamp_level({3'b000, count}, i_cfg.min_level, i_cfg.max_level);
        end
    end

endmodule

`default_nettype wire

### design/abc_level.sv
// Level stage: hold target, ramp, manual commands and result register.
`default_nettype none

module abc_level import abc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire t_item             i_item,
    input  wire logic [LEVEL_W-1:0] i_mapped,
    abc_out_if.source              o_out
);

    logic               r_valid;
    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] r_hold;
    logic               r_auto_on;
    logic               r_drive;
    logic               r_notify;

    logic [LEVEL_W-1:0] n_level;
    logic [LEVEL_W-1:0] n_hold;
    logic               n_drive;
    logic               n_notify;

    logic                take;
    logic [LEVEL_W-1:0]  hold_eff;
    logic signed [9:0]   diff;
    logic                moved;
    logic [LEVEL_W-1:0]  goal;
    logic [LEVEL_W-1:0]  gap;
    logic [LEVEL_W-1:0]  ramped;
    logic signed [10:0]  adj_sum;
    logic [LEVEL_W-1:0]  target;

    assign o_ready           = !r_valid || o_out.ready;
    assign take              = i_valid && o_ready;
    assign o_out.valid       = r_valid;
    assign o_out.level       = r_level;
    assign o_out.auto_on     = r_auto_on;
    assign o_out.drive_write = r_drive;
    assign o_out.notify      = r_notify;

    always_comb begin
        hold_eff = i_item.reload ? r_level : r_hold;
        diff     = $signed({2'b00, i_mapped}) - $signed({2'b00, hold_eff});
        moved    = (diff >= $signed({2'b00, i_cfg.hold_up_margin}))
                || (diff <= -$signed({2'b00, i_cfg.hold_down_margin}));
        goal     = moved ? i_mapped : hold_eff;

        ramped = r_level;
        if (r_level < goal) begin
            gap    = goal - r_level;
            ramped = r_level + ((gap > i_cfg.ramp_up_step) ? i_cfg.ramp_up_step : gap);
        end else begin
            gap    = r_level - goal;
            ramped = r_level - ((gap > i_cfg.ramp_down_step) ? i_cfg.ramp_down_step : gap);
        end

        adj_sum = $signed({3'b000, r_level})
                + $signed({{2{i_item.adjust_delta[DELTA_W-1]}}, i_item.adjust_delta});
        if (i_item.cmd == CMD_LEVEL) begin
            target = clamp_level({3'b000, i_item.manual_level},
                                 i_cfg.min_level, i_cfg.max_level);
        end else begin
            target = clamp_level({3'b000, clamp_level(adj_sum, i_cfg.min_level,
                                                      i_cfg.max_level)},
                                 i_cfg.min_level, i_cfg.max_level);
        end

        n_level  = r_level;
        n_hold   = r_hold;
        n_drive  = 1'b0;
        n_notify = 1'b0;
        case (i_item.cmd)
            CMD_SAMPLE: begin
                if (i_item.sample_on) begin
                    n_hold   = goal;
                    n_level  = ramped;
                    n_drive  = ramped != r_level;
                    n_notify = ramped != r_level;
                end
            end
            CMD_AUTO: begin
                n_notify = i_item.auto_old != i_item.enable;
            end
            default: begin
                n_level  = target;
                n_drive  = target != r_level;
                n_notify = i_item.auto_old || (target != r_level);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_level <= RST_MAX_LEVEL;
            r_hold  <= RST_MAX_LEVEL;
        end else if (take) begin
            r_valid <= 1'b1;
            r_level <= n_level;
            r_hold  <= n_hold;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_auto_on <= i_item.auto_new;
            r_drive   <= n_drive;
            r_notify  <= n_notify;
        end
    end

endmodule

`default_nettype wire

### design/auto_brightness_controller.sv
// Top level: automatic display brightness controller.
//
// Channels: i_in takes one command item (lux sample, auto enable, manual
// level or signed manual adjust); o_out gives exactly one result item per
// command (level, auto_on, drive_write, notify). i_cfg writes the seven
// setting registers by index; unused indexes are dropped. It is always ready.
// Throughput: one item per cycle while o_out.ready is high. Three
// registered stages carry the item: average update, boundary compare
// against the level table, then hold, ramp and manual commands into the
// output register.
// Stall: while o_out.ready is low the result holds and the earlier stages
// keep filling; i_in.ready drops once all three stages hold an item.
// Reset: settings take their defaults, level and hold target are 100,
// auto mode is off, the average is zero and the next sample reloads it.
`default_nettype none

module auto_brightness_controller import abc_pkg::*; #(
    parameter int LUX_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    abc_in_if.sink    i_in,
    abc_out_if.source o_out,
    abc_cfg_if.sink   i_cfg
);

    t_cfg                cfg;
    logic                s1_valid;
    t_item               s1_item;
    logic [LUX_BITS-1:0] s1_avg;
    logic                s2_ready;
    logic                s2_valid;
    t_item               s2_item;
    logic [LEVEL_W-1:0]  s2_mapped;
    logic                s3_ready;

    abc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    abc_avg #(.LUX_BITS(LUX_BITS)) u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (cfg),
        .i_ready (s2_ready),
        .o_valid (s1_valid),
        .o_item  (s1_item),
        .o_avg   (s1_avg)
    );

    abc_map #(.LUX_BITS(LUX_BITS)) u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (s1_valid),
        .o_ready  (s2_ready),
        .i_item   (s1_item),
        .i_avg    (s1_avg),
        .i_ready  (s3_ready),
        .o_valid  (s2_valid),
        .o_item   (s2_item),
        .o_mapped (s2_mapped)
    );

    abc_level u_level (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (s2_valid),
        .o_ready  (s3_ready),
        .i_item   (s2_item),
        .i_mapped (s2_mapped),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

### bench/auto_brightness_controller_test.sv
// Self-checking bench for the brightness controller: command items in, level reports checked.
`default_nettype none

module auto_brightness_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    import abc_pkg::*;

    localparam logic [2:0] REG_SPARE   = 3'd7;
    localparam int         STALL_LIMIT = 2000;
    localparam int         SHOW_LIMIT  = 100;

    typedef struct packed {
        t_cmd              cmd;
        logic [15:0]       lux;
        logic              enable;
        logic [7:0]        manual_level;
        logic signed [8:0] adjust_delta;
    } brightness_cmd_t;

    typedef struct packed {
        logic [7:0] level;
        logic       auto_on;
        logic       drive_write;
        logic       notify;
    } level_report_t;

    class brightness_scoreboard;
        logic [7:0]    lvl_min, lvl_max, up_step, down_step, up_margin, down_margin;
        logic [3:0]    avg_shift;
        logic [7:0]    level, hold;
        logic          auto_on, reload;
        logic [15:0]   lux_avg;
        logic [31:0]   bound [255];
        level_report_t expected_reports [$];
        int            mismatches;
        int            shown;

        function new();
            build_bounds();
            lvl_min     = RST_MIN_LEVEL;
            lvl_max     = RST_MAX_LEVEL;
            avg_shift   = RST_AVG_SHIFT;
            up_step     = RST_RAMP_UP;
            down_step   = RST_RAMP_DOWN;
            up_margin   = RST_HOLD_UP;
            down_margin = RST_HOLD_DOWN;
            level       = RST_MAX_LEVEL;
            hold        = RST_MAX_LEVEL;
            auto_on     = 1'b0;
            reload      = 1'b1;
            lux_avg     = '0;
            mismatches  = 0;
            shown       = 0;
        endfunction

        function logic [63:0] exp_series(int unsigned div, bit alternate);
            logic [63:0] acc, t;
            acc = 64'd1 << 62;
            t   = acc;
            for (int n = 1; n < 64; n++) begin
                t = t / (64'(div) * 64'(n));
                if (t == 64'd0) break;
                if (alternate && (n % 2 == 1)) acc = acc - t;
                else acc = acc + t;
            end
            return acc;
        endfunction

        function logic [63:0] q62_product(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            p = p >> 62;
            return p[63:0];
        endfunction

        function logic [31:0] round_up_q38(logic [63:0] v);
            return 32'((v >> 38) + 64'(v[37:0] != 38'd0));
        endfunction

        function void build_bounds();
            logic [63:0] up, down, start, v;
            bit          capped;
            up     = exp_series(15, 1'b0);
            down   = exp_series(15, 1'b1);
            start  = (exp_series(30, 1'b0) >> 24) * 64'd50;
            bound[50] = round_up_q38(start);
            v = start;
            for (int k = 49; k >= 0; k--) begin
                v = q62_product(v, down);
                bound[k] = round_up_q38(v);
            end
            v = start;
            capped = 1'b0;
            for (int k = 51; k < 255; k++) begin
                if (!capped) begin
                    v = q62_product(v, up);
                    capped = (v >= (64'd1 << 62));
                end
                bound[k] = capped ? 32'hFFFF_FFFF : round_up_q38(v);
            end
        endfunction

        function int clamp_to_range(int v);
            if (v < int'(lvl_min)) return int'(lvl_min);
            if (v > int'(lvl_max)) return int'(lvl_max);
            return v;
        endfunction

        function int map_average();
            int count;
            count = 0;
            for (int i = 0; i < 255; i++) begin
                if ({16'd0, lux_avg} >= bound[i]) count++;
            end
            return clamp_to_range(count);
        endfunction

        function void write_reg(logic [2:0] idx, logic [7:0] data);
            case (idx)
                REG_MIN_LEVEL: lvl_min     = data;
                REG_MAX_LEVEL: lvl_max     = data;
                REG_AVG_SHIFT: avg_shift   = data[3:0];
                REG_RAMP_UP:   up_step     = data;
                REG_RAMP_DOWN: down_step   = data;
                REG_HOLD_UP:   up_margin   = data;
                REG_HOLD_DOWN: down_margin = data;
                default: ;
            endcase
        endfunction

        function void note_command(brightness_cmd_t c);
            int            a, x, mapped, d, cur, goal, target;
            level_report_t r;
            r = '0;
            case (c.cmd)
                CMD_SAMPLE: begin
                    if (auto_on) begin
                        a = int'(lux_avg);
                        x = int'(c.lux);
                        if (reload) begin
                            a      = x;
                            hold   = level;
                            reload = 1'b0;
                        end else if (x >= a) begin
                            a = a + ((x - a) >> avg_shift);
                        end else begin
                            a = a - ((a - x + (1 << avg_shift) - 1) >> avg_shift);
                        end
                        lux_avg = a[15:0];
                        mapped  = map_average();
                        d       = mapped - int'(hold);
                        if (d >= int'(up_margin) || d <= -int'(down_margin)) begin
                            hold = mapped[7:0];
                        end
                        cur  = int'(level);
                        goal = int'(hold);
                        if (cur < goal) begin
                            cur = cur + ((goal - cur) > int'(up_step) ? int'(up_step)
                                                                       : goal - cur);
                        end else if (cur > goal) begin
                            cur = cur - ((cur - goal) > int'(down_step) ? int'(down_step)
                                                                         : cur - goal);
                        end
                        if (cur != int'(level)) begin
                            level         = cur[7:0];
                            r.drive_write = 1'b1;
                            r.notify      = 1'b1;
                        end
                    end
                end
                CMD_AUTO: begin
                    if (auto_on != c.enable) r.notify = 1'b1;
                    auto_on = c.enable;
                    reload  = 1'b1;
                end
                default: begin
                    if (c.cmd == CMD_LEVEL) begin
                        target = clamp_to_range(int'(c.manual_level));
                    end else begin
                        target = clamp_to_range(clamp_to_range(int'(level) +
                                                               int'($signed(c.adjust_delta))));
                    end
                    if (auto_on) r.notify = 1'b1;
                    auto_on = 1'b0;
                    reload  = 1'b1;
                    if (target != int'(level)) begin
                        level         = target[7:0];
                        r.drive_write = 1'b1;
                        r.notify      = 1'b1;
                    end
                end
            endcase
            r.level   = level;
            r.auto_on = auto_on;
            expected_reports.push_back(r);
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void flag(string what, int want, int got);
            mismatches++;
            if (shown < SHOW_LIMIT) begin
                shown++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            end
        endfunction

        function void check_report(logic [7:0] lvl, logic aon, logic drv, logic ntf);
            level_report_t want;
            if (expected_reports.size() == 0) begin
                flag("unexpected report level", -1, int'(lvl));
                return;
            end
            want = expected_reports.pop_front();
            if (lvl !== want.level)       flag("level", int'(want.level), int'(lvl));
            if (aon !== want.auto_on)     flag("auto_on", int'(want.auto_on), int'(aon));
            if (drv !== want.drive_write) flag("drive_write", int'(want.drive_write), int'(drv));
            if (ntf !== want.notify)      flag("notify", int'(want.notify), int'(ntf));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    abc_in_if  cmd_ch ();
    abc_out_if report_ch ();
    abc_cfg_if setting_ch ();

    auto_brightness_controller dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (report_ch),
        .i_cfg   (setting_ch)
    );

    brightness_scoreboard sb;
    int cmd_calm;
    int reply_calm;
    int lux_base;
    int idle_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int next_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic int log_lux();
        int bits;
        bits = $urandom_range(0, 16);
        if (bits == 0) return 0;
        return (1 << (bits - 1)) + int'($urandom_range(0, (1 << (bits - 1)) - 1));
    endfunction

    function automatic logic [15:0] next_lux();
        int v, span;
        case ($urandom_range(0, 39))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: ;
        endcase
        if ($urandom_range(0, 24) == 0) lux_base = log_lux();
        span = lux_base / 8 + 1;
        v = lux_base + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    function automatic brightness_cmd_t make_cmd(t_cmd op, int lux, bit en, int lvl, int delta);
        brightness_cmd_t c;
        c.cmd          = op;
        c.lux          = lux[15:0];
        c.enable       = en;
        c.manual_level = lvl[7:0];
        c.adjust_delta = delta[8:0];
        return c;
    endfunction

    function automatic logic [7:0] pick_step();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(1, 6));
    endfunction

    function automatic t_cfg random_settings();
        t_cfg c;
        c.min_level        = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(0, 40));
        c.max_level        = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(90, 255));
        c.average_shift    = 4'($urandom_range(0, 15));
        c.ramp_up_step     = pick_step();
        c.ramp_down_step   = pick_step();
        c.hold_up_margin   = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(0, 10));
        c.hold_down_margin = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(0, 10));
        return c;
    endfunction

    task automatic send_command(input brightness_cmd_t c);
        int gap;
        gap = next_gap(cmd_calm);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= c.cmd;
        cmd_ch.lux          <= c.lux;
        cmd_ch.enable       <= c.enable;
        cmd_ch.manual_level <= c.manual_level;
        cmd_ch.adjust_delta <= c.adjust_delta;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_command(c);
    endtask

    task automatic settle_results();
        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic program_settings(input t_cfg c, input bit poke_spare);
        logic [2:0] idx [8];
        logic [7:0] dat [8];
        int         n;
        idx[0] = REG_MIN_LEVEL; dat[0] = c.min_level;
        idx[1] = REG_MAX_LEVEL; dat[1] = c.max_level;
        idx[2] = REG_AVG_SHIFT; dat[2] = {4'($urandom), c.average_shift};
        idx[3] = REG_RAMP_UP;   dat[3] = c.ramp_up_step;
        idx[4] = REG_RAMP_DOWN; dat[4] = c.ramp_down_step;
        idx[5] = REG_HOLD_UP;   dat[5] = c.hold_up_margin;
        idx[6] = REG_HOLD_DOWN; dat[6] = c.hold_down_margin;
        idx[7] = REG_SPARE;     dat[7] = 8'($urandom);
        n = poke_spare ? 8 : 7;
        for (int i = 0; i < n; i++) begin
            setting_ch.valid <= 1'b1;
            setting_ch.index <= idx[i];
            setting_ch.data  <= dat[i];
            do @(posedge i_clk); while (!setting_ch.ready);
            sb.write_reg(idx[i], dat[i]);
        end
        setting_ch.valid <= 1'b0;
    endtask

    task automatic run_session(input int items);
        int              sent, r;
        brightness_cmd_t c;
        sent = 0;
        while (sent < items) begin
            c.cmd          = CMD_SAMPLE;
            c.lux          = 16'($urandom);
            c.enable       = 1'($urandom);
            c.manual_level = 8'($urandom);
            c.adjust_delta = 9'($urandom);
            if (!sb.auto_on && $urandom_range(0, 9) < 7) begin
                c.cmd    = CMD_AUTO;
                c.enable = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 78) begin
                    c.lux = next_lux();
                end else if (r < 84) begin
                    c.cmd = CMD_LEVEL;
                end else if (r < 90) begin
                    c.cmd = CMD_ADJUST;
                    if ($urandom_range(0, 3) != 0) c.adjust_delta = 9'($urandom_range(0, 40) - 20);
                end else if (r < 94) begin
                    c.cmd = CMD_AUTO;
                end else begin
                    c.cmd = t_cmd'($urandom_range(0, 3));
                end
            end
            if (!(c.cmd == CMD_SAMPLE && !sb.auto_on)) sent++;
            send_command(c);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && report_ch.valid && report_ch.ready) begin
            sb.check_report(report_ch.level, report_ch.auto_on, report_ch.drive_write,
                            report_ch.notify);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (report_ch.valid && report_ch.ready)
            || (setting_ch.valid && setting_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("auto_brightness_controller verification failed");
            $finish;
        end
    end

    initial begin : result_sink
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = next_gap(reply_calm);
            if (gap > 0) begin
                report_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            report_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!report_ch.valid);
        end
    end

    initial begin : stimulus
        t_cfg c;
        sb = new();
        cmd_calm   = 0;
        reply_calm = 0;
        lux_base   = 1000;
        i_rst_n                <= 1'b0;
        cmd_ch.valid           <= 1'b0;
        cmd_ch.command         <= CMD_SAMPLE;
        cmd_ch.lux             <= '0;
        cmd_ch.enable          <= 1'b0;
        cmd_ch.manual_level    <= '0;
        cmd_ch.adjust_delta    <= '0;
        report_ch.ready        <= 1'b0;
        setting_ch.valid       <= 1'b0;
        setting_ch.index       <= REG_MIN_LEVEL;
        setting_ch.data        <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_command(make_cmd(CMD_SAMPLE, 0, 1, 255, -1));
        send_command(make_cmd(CMD_SAMPLE, 65535, 0, 0, 0));
        send_command(make_cmd(CMD_AUTO, 0, 1, 0, 0));
        send_command(make_cmd(CMD_AUTO, 0, 1, 0, 0));
        send_command(make_cmd(CMD_SAMPLE, 1000, 0, 0, 0));
        send_command(make_cmd(CMD_SAMPLE, 0, 0, 0, 0));
        send_command(make_cmd(CMD_SAMPLE, 65535, 0, 0, 0));
        send_command(make_cmd(CMD_SAMPLE, 65535, 0, 0, 0));
        send_command(make_cmd(CMD_SAMPLE, 65535, 0, 0, 0));
        send_command(make_cmd(CMD_SAMPLE, 0, 0, 0, 0));
        send_command(make_cmd(CMD_SAMPLE, 1, 0, 0, 0));
        send_command(make_cmd(CMD_SAMPLE, 300, 0, 0, 0));
        send_command(make_cmd(CMD_AUTO, 0, 0, 0, 0));
        send_command(make_cmd(CMD_LEVEL, 0, 0, 0, 0));
        send_command(make_cmd(CMD_LEVEL, 0, 0, 255, 0));
        send_command(make_cmd(CMD_ADJUST, 0, 0, 0, -255));
        send_command(make_cmd(CMD_ADJUST, 0, 0, 0, 255));
        send_command(make_cmd(CMD_ADJUST, 0, 0, 0, -1));
        send_command(make_cmd(CMD_ADJUST, 0, 0, 0, 0));
        send_command(make_cmd(CMD_AUTO, 0, 1, 0, 0));
        send_command(make_cmd(CMD_SAMPLE, 1, 0, 0, 0));
        send_command(make_cmd(CMD_SAMPLE, 2, 0, 0, 0));
        send_command(make_cmd(CMD_LEVEL, 65535, 1, 50, 255));
        send_command(make_cmd(CMD_SAMPLE, 40000, 1, 0, 0));
        settle_results();

        c.min_level = 8'd0;   c.max_level = 8'd255; c.average_shift = 4'd0;
        c.ramp_up_step = 8'd255; c.ramp_down_step = 8'd255;
        c.hold_up_margin = 8'd0; c.hold_down_margin = 8'd0;
        program_settings(c, 1'b1);
        run_session(250);
        settle_results();

        c.min_level = 8'd255; c.max_level = 8'd0;   c.average_shift = 4'd15;
        c.ramp_up_step = 8'd1; c.ramp_down_step = 8'd1;
        c.hold_up_margin = 8'd255; c.hold_down_margin = 8'd255;
        program_settings(c, 1'b0);
        run_session(150);
        settle_results();

        c.min_level = 8'd200; c.max_level = 8'd30;  c.average_shift = 4'd1;
        c.ramp_up_step = 8'd0; c.ramp_down_step = 8'd3;
        c.hold_up_margin = 8'd1; c.hold_down_margin = 8'd0;
        program_settings(c, 1'b0);
        run_session(150);
        settle_results();

        for (int p = 0; p < 6; p++) begin
            program_settings(random_settings(), 1'($urandom_range(0, 1)));
            run_session(210);
            settle_results();
        end

        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("auto_brightness_controller verification clean");
        end else begin
            $display("auto_brightness_controller verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
design/abc_pkg.sv
design/abc_in_if.sv
design/abc_out_if.sv
design/abc_cfg_if.sv
design/abc_cfg_regs.sv
design/abc_avg.sv
design/abc_map.sv
design/abc_level.sv
design/auto_brightness_controller.sv
bench/auto_brightness_controller_test.sv
